>>> design/tgq_pkg.sv
// Package for the text glyph quad generator.
// Holds the queue entry types, the character and register codes, and the palette table.
// No dependencies.
package tgq_pkg;

    localparam int PALETTE_ENTRIES = 25;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic CFG_DISPLAY_ENABLE    = 1'b0;
    localparam logic CFG_PROGRESSIVE_SCALE = 1'b1;

    localparam logic [7:0] CODE_NONE     = 8'h00;
    localparam logic [7:0] CODE_NEWLINE  = 8'h0A;
    localparam logic [7:0] CODE_SPACE    = 8'h20;
    localparam logic [7:0] CODE_SPECIAL1 = 8'h01;
    localparam logic [7:0] CODE_SPECIAL2 = 8'h02;
    localparam logic [7:0] CODE_SPECIAL3 = 8'h03;
    localparam logic [7:0] CODE_SPECIAL4 = 8'h04;
    localparam logic [7:0] CELL_SPECIAL1 = 8'h7D;
    localparam logic [7:0] CELL_SPECIAL2 = 8'h60;
    localparam logic [7:0] CELL_SPECIAL3 = 8'h7C;
    localparam logic [7:0] CELL_SPECIAL4 = 8'h7B;
    localparam logic [7:0] CELL_BASE     = 8'h20;

    localparam logic       FUNC_BEGIN = 1'b0;
    localparam logic       FUNC_CHAR  = 1'b1;

    localparam logic [15:0] SCALE_BIAS     = 16'd24576;
    localparam logic [15:0] SCALE_Y_OFFSET = 16'd56;

    localparam logic [1:0] VTX_TOP_LEFT     = 2'd0;
    localparam logic [1:0] VTX_TOP_RIGHT    = 2'd1;
    localparam logic [1:0] VTX_BOTTOM_RIGHT = 2'd2;
    localparam logic [1:0] VTX_BOTTOM_LEFT  = 2'd3;

    localparam logic [8:0] GLYPH_W = 9'd8;
    localparam logic [7:0] GLYPH_H = 8'd16;

    typedef struct packed {
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [7:0]  u;
        logic [6:0]  v;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_quad;

    typedef struct packed {
        logic  valid;
        t_quad quad;
    } t_quad_push;

    typedef struct packed {
        logic  valid;
        t_quad quad;
    } t_quad_head;

    function automatic logic [31:0] palette_color(input logic [4:0] idx);
        logic [31:0] col;
        case (idx)
            5'd0:    col = 32'hB0B0B0FF;
            5'd1:    col = 32'h0000FFFF;
            5'd2:    col = 32'hFF0000FF;
            5'd3:    col = 32'hFF00FFFF;
            5'd4:    col = 32'h00FF00FF;
            5'd5:    col = 32'h00FFFFFF;
            5'd6:    col = 32'hFFFF00FF;
            5'd7:    col = 32'h808080FF;
            5'd8:    col = 32'h808080FF;
            5'd9:    col = 32'h000080FF;
            5'd10:   col = 32'h800000FF;
            5'd11:   col = 32'h800080FF;
            5'd12:   col = 32'h008000FF;
            5'd13:   col = 32'h008080FF;
            5'd14:   col = 32'h808000FF;
            5'd15:   col = 32'h404040FF;
            5'd16:   col = 32'hA0A0A0FF;
            5'd17:   col = 32'h686868FF;
            5'd18:   col = 32'h00C000FF;
            5'd19:   col = 32'h005800FF;
            5'd20:   col = 32'h585858FF;
            5'd21:   col = 32'h303030FF;
            5'd22:   col = 32'hFF9600FF;
            5'd23:   col = 32'h905100FF;
            5'd24:   col = 32'h60A0A0FF;
            default: col = 32'h00000000;
        endcase
        return col;
    endfunction

    function automatic logic [7:0] glyph_cell(input logic [7:0] code);
        logic [7:0] c;
        case (code)
            CODE_SPECIAL1: c = CELL_SPECIAL1;
            CODE_SPECIAL2: c = CELL_SPECIAL2;
            CODE_SPECIAL3: c = CELL_SPECIAL3;
            CODE_SPECIAL4: c = CELL_SPECIAL4;
            default:       c = code;
        endcase
        return c - CELL_BASE;
    endfunction

endpackage

>>> design/tgq_in_if.sv
// Input channel of the text glyph quad generator: valid/ready with one text item.
// No dependencies.
interface tgq_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic        [4:0]  color_index;
    logic        [7:0]  cell_width;
    logic        [7:0]  cell_height;
    logic        [7:0]  char_code;

    modport source (output valid, func, start_x, start_y, color_index, cell_width,
                    cell_height, char_code, input ready);
    modport sink   (input valid, func, start_x, start_y, color_index, cell_width,
                    cell_height, char_code, output ready);
endinterface

>>> design/tgq_out_if.sv
// Output channel of the text glyph quad generator: valid/ready with one vertex.
// No dependencies.
interface tgq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic        [8:0]  tex_u;
    logic        [7:0]  tex_v;
    logic        [7:0]  red;
    logic        [7:0]  green;
    logic        [7:0]  blue;
    logic        [7:0]  alpha;
    logic               quad_end;

    modport source (output valid, vertex_x, vertex_y, tex_u, tex_v, red, green, blue,
                    alpha, quad_end, input ready);
    modport sink   (input valid, vertex_x, vertex_y, tex_u, tex_v, red, green, blue,
                    alpha, quad_end, output ready);
endinterface

>>> design/tgq_front.sv
// Front end: accepts text items, keeps the cursor state and builds quad descriptors.
// Depends on tgq_pkg and tgq_in_if.
module tgq_front
    import tgq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data,
    tgq_in_if.sink     i_item,
    input  logic       i_queue_full,
    output t_quad_push o_push
);

    logic        r_display_enable;
    logic        r_progressive_scale;
    logic [15:0] r_cursor_x,     n_cursor_x;
    logic [15:0] r_cursor_y,     n_cursor_y;
    logic [15:0] r_line_start_x, n_line_start_x;
    logic [7:0]  r_advance_width, n_advance_width;
    logic [15:0] r_line_height,  n_line_height;
    logic [4:0]  r_text_color,   n_text_color;

    logic        accept;
    logic [15:0] y_biased;
    logic [17:0] y_times3;
    logic [15:0] y_scaled;
    logic [9:0]  h_times3;
    logic [15:0] h_scaled;
    logic [7:0]  glyph_idx;
    logic [4:0]  color_idx;
    logic [31:0] color;
    logic        is_black;
    logic        draws;

    assign i_item.ready = !i_queue_full;
    assign accept       = i_item.valid && i_item.ready;

    // floor(3*y/4) + SCALE_Y_OFFSET on a signed value: bias to unsigned, scale, remove the exact bias.
    assign y_biased = i_item.start_y ^ 16'h8000;
    assign y_times3 = {2'b00, y_biased} + {1'b0, y_biased, 1'b0};
    assign y_scaled = y_times3[17:2] - SCALE_BIAS + SCALE_Y_OFFSET;
    assign h_times3 = {2'b00, i_item.cell_height} + {1'b0, i_item.cell_height, 1'b0};
    assign h_scaled = {8'd0, h_times3[9:2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_enable    <= 1'b0;
            r_progressive_scale <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DISPLAY_ENABLE:    r_display_enable    <= i_cfg_data;
                CFG_PROGRESSIVE_SCALE: r_progressive_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_cursor_x      = r_cursor_x;
        n_cursor_y      = r_cursor_y;
        n_line_start_x  = r_line_start_x;
        n_advance_width = r_advance_width;
        n_line_height   = r_line_height;
        n_text_color    = r_text_color;
        draws           = 1'b0;
        if (accept) begin
            if (i_item.func == FUNC_BEGIN) begin
                n_cursor_x      = i_item.start_x;
                n_line_start_x  = i_item.start_x;
                n_text_color    = i_item.color_index;
                n_advance_width = i_item.cell_width;
                if (r_progressive_scale) begin
                    n_cursor_y    = y_scaled;
                    n_line_height = h_scaled;
                end else begin
                    n_cursor_y    = i_item.start_y;
                    n_line_height = {8'd0, i_item.cell_height};
                end
            end else if (i_item.char_code == CODE_NEWLINE) begin
                n_cursor_y = r_cursor_y + r_line_height;
                n_cursor_x = r_line_start_x;
            end else if (i_item.char_code != CODE_NONE) begin
                n_cursor_x = r_cursor_x + {8'd0, r_advance_width};
                draws      = (i_item.char_code != CODE_SPACE) && r_display_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x      <= '0;
            r_cursor_y      <= '0;
            r_line_start_x  <= '0;
            r_advance_width <= '0;
            r_line_height   <= '0;
            r_text_color    <= '0;
        end else begin
            r_cursor_x      <= n_cursor_x;
            r_cursor_y      <= n_cursor_y;
            r_line_start_x  <= n_line_start_x;
            r_advance_width <= n_advance_width;
            r_line_height   <= n_line_height;
            r_text_color    <= n_text_color;
        end
    end

    // Out-of-range color indexes use the last palette entry; black draws white.
    assign color_idx = (r_text_color >= 5'(PALETTE_ENTRIES)) ?
                       5'(PALETTE_ENTRIES - 1) : r_text_color;
    assign color     = palette_color(color_idx);
    assign is_black  = (color[31:8] == 24'd0);
    assign glyph_idx = glyph_cell(i_item.char_code);

    always_comb begin
        o_push.valid      = (i_item.func == FUNC_CHAR) && draws;
        o_push.quad.x0    = r_cursor_x;
        o_push.quad.y0    = r_cursor_y;
        o_push.quad.x1    = r_cursor_x + {8'd0, r_advance_width};
        o_push.quad.y1    = r_cursor_y + r_line_height;
        o_push.quad.u     = {glyph_idx[4:0], 3'b000};
        o_push.quad.v     = {glyph_idx[7:5], 4'b0000};
        o_push.quad.red   = is_black ? 8'hFF : color[31:24];
        o_push.quad.green = is_black ? 8'hFF : color[23:16];
        o_push.quad.blue  = is_black ? 8'hFF : color[15:8];
        o_push.quad.alpha = color[7:0];
    end

endmodule

>>> design/tgq_queue.sv
// Short queue of quad descriptors between the front end and the vertex emitter.
// Depends on tgq_pkg.
module tgq_queue
    import tgq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_quad_push i_push,
    input  logic       i_pop,
    output logic       o_full,
    output t_quad_head o_head
);

    t_quad                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [QUEUE_CNT_W-1:0]  r_count;
    logic                    do_push;
    logic                    do_pop;

    assign o_full      = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.quad  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.quad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("quad pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("quad popped from an empty queue");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

    a_pointers_track_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers differ while the queue is empty");

endmodule

>>> design/tgq_back.sv
// Back end: expands each quad descriptor into four vertices on the output channel.
// Depends on tgq_pkg and tgq_out_if.
module tgq_back
    import tgq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_quad_head i_head,
    output logic       o_pop,
    tgq_out_if.source  o_vertex
);

    logic        r_busy,  n_busy;
    logic [1:0]  r_k,     n_k;
    t_quad       r_quad;
    logic        r_out_valid;
    logic [15:0] r_vx;
    logic [15:0] r_vy;
    logic [8:0]  r_tu;
    logic [7:0]  r_tv;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  r_alpha;
    logic        r_quad_end;

    logic        advance;
    logic        emit;
    logic        load;
    logic        right;
    logic        bottom;

    assign advance = !r_out_valid || o_vertex.ready;
    assign emit    = r_busy && advance;
    // New descriptors load when idle or as the last vertex enters the output register.
    assign load    = i_head.valid && (!r_busy || (emit && r_k == VTX_BOTTOM_LEFT));
    assign o_pop   = load;
    assign right   = (r_k == VTX_TOP_RIGHT) || (r_k == VTX_BOTTOM_RIGHT);
    assign bottom  = (r_k == VTX_BOTTOM_RIGHT) || (r_k == VTX_BOTTOM_LEFT);

    always_comb begin
        n_busy = r_busy;
        n_k    = r_k;
        if (load) begin
            n_busy = 1'b1;
            n_k    = VTX_TOP_LEFT;
        end else if (emit) begin
            n_k = r_k + 1'b1;
            if (r_k == VTX_BOTTOM_LEFT) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= VTX_TOP_LEFT;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_k    <= n_k;
            if (advance) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_quad <= i_head.quad;
        end
        if (emit) begin
            r_vx       <= right  ? r_quad.x1 : r_quad.x0;
            r_vy       <= bottom ? r_quad.y1 : r_quad.y0;
            r_tu       <= {1'b0, r_quad.u} + (right ? GLYPH_W : 9'd0);
            r_tv       <= {1'b0, r_quad.v} + (bottom ? GLYPH_H : 8'd0);
            r_red      <= r_quad.red;
            r_green    <= r_quad.green;
            r_blue     <= r_quad.blue;
            r_alpha    <= r_quad.alpha;
            r_quad_end <= (r_k == VTX_BOTTOM_LEFT);
        end
    end

    assign o_vertex.valid    = r_out_valid;
    assign o_vertex.vertex_x = r_vx;
    assign o_vertex.vertex_y = r_vy;
    assign o_vertex.tex_u    = r_tu;
    assign o_vertex.tex_v    = r_tv;
    assign o_vertex.red      = r_red;
    assign o_vertex.green    = r_green;
    assign o_vertex.blue     = r_blue;
    assign o_vertex.alpha    = r_alpha;
    assign o_vertex.quad_end = r_quad_end;

endmodule

>>> design/text_glyph_quad_generator_top.sv
// Top level of the text glyph quad generator.
// Depends on tgq_pkg, tgq_in_if, tgq_out_if, tgq_front, tgq_queue and tgq_back.
//
// Usage: text items arrive on i_item (valid/ready). A begin item loads the cursor, line
// start, palette color and cell size; a character item draws one glyph as a quad of four
// vertices on o_vertex (valid/ready), top left, top right, bottom right, bottom left, with
// quad_end set on the last. Spaces, newlines, begin items and code zero produce nothing.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while the block is idle.
// The front end takes one item per cycle while the queue is not full and queues up to four
// quad descriptors; the vertex emitter sends one vertex per cycle while the receiver is
// ready, and the output port sets the sustained rate. The first vertex of a quad passes
// through the queue, the descriptor register and the output register before it appears.
// When the receiver stalls, the vertex held in the output register stays; the queue keeps
// filling and i_item.ready drops only once four quads wait. Non-drawing items pass through
// the front end at one per cycle as long as the queue is not full.
// Reset clears the configuration, the cursor state, the queue and the output valid.
module text_glyph_quad_generator_top
    import tgq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic      i_cfg_data,
    tgq_in_if.sink    i_item,
    tgq_out_if.source o_vertex
);

    t_quad_push push;
    t_quad_head head;
    logic       queue_full;
    logic       pop;

    tgq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (i_item),
        .i_queue_full (queue_full),
        .o_push       (push)
    );

    tgq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    tgq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_vertex (o_vertex)
    );

endmodule

>>> tb/tgq_vertex_checker.sv
`timescale 1ns / 1ps
// Checker for the text glyph quad generator: watches the item and vertex channels, predicts
// the vertices of every accepted text item and compares them in order of arrival.
// Depends on tgq_pkg, tgq_in_if and tgq_out_if.
module tgq_vertex_checker
    import tgq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_index,
    input  logic i_cfg_data,
    tgq_in_if    i_item,
    tgq_out_if   i_vertex,
    output int   o_error_count,
    output int   o_outstanding
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [8:0]  u;
        logic [7:0]  v;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
    } t_vertex;

    // RGBA per palette slot; slots past the populated entries are transparent black.
    localparam logic [31:0] RGBA_TABLE [32] = '{
        32'hB0B0B0FF, 32'h0000FFFF, 32'hFF0000FF, 32'hFF00FFFF, 32'h00FF00FF, 32'h00FFFFFF,
        32'hFFFF00FF, 32'h808080FF, 32'h808080FF, 32'h000080FF, 32'h800000FF, 32'h800080FF,
        32'h008000FF, 32'h008080FF, 32'h808000FF, 32'h404040FF, 32'hA0A0A0FF, 32'h686868FF,
        32'h00C000FF, 32'h005800FF, 32'h585858FF, 32'h303030FF, 32'hFF9600FF, 32'h905100FF,
        32'h60A0A0FF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
    };

    logic        display_on;
    logic        scale_on;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic [15:0] line_start_x;
    logic [15:0] line_height;
    logic [7:0]  advance;
    logic [4:0]  text_color;
    t_vertex     expected_vertices [$];
    t_vertex     observed;
    t_vertex     oldest;

    // floor(3 * val / 4) on a 16-bit two's complement value.
    function automatic logic [15:0] three_quarters(input logic [15:0] val);
        logic signed [17:0] tripled;
        tripled = $signed({{2{val[15]}}, val}) * 18'sd3;
        return tripled[17:2];
    endfunction

    task automatic load_text_header();
        cursor_x     = i_item.start_x;
        line_start_x = i_item.start_x;
        text_color   = i_item.color_index;
        advance      = i_item.cell_width;
        if (scale_on) begin
            cursor_y    = three_quarters(i_item.start_y) + SCALE_Y_OFFSET;
            line_height = three_quarters({8'd0, i_item.cell_height});
        end else begin
            cursor_y    = i_item.start_y;
            line_height = {8'd0, i_item.cell_height};
        end
    endtask

    task automatic predict_glyph_quad(input logic [7:0] code);
        logic [7:0]  glyph_idx;
        logic [8:0]  u;
        logic [7:0]  v;
        logic [4:0]  slot;
        logic [31:0] rgba;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [1:0]  corner;
        logic        right;
        logic        bottom;
        t_vertex     vtx;
        x0 = cursor_x;
        y0 = cursor_y;
        cursor_x = cursor_x + {8'd0, advance};
        if (code == CODE_SPACE || !display_on)
            return;
        case (code)
            CODE_SPECIAL1: glyph_idx = CELL_SPECIAL1;
            CODE_SPECIAL2: glyph_idx = CELL_SPECIAL2;
            CODE_SPECIAL3: glyph_idx = CELL_SPECIAL3;
            CODE_SPECIAL4: glyph_idx = CELL_SPECIAL4;
            default:       glyph_idx = code;
        endcase
        glyph_idx = glyph_idx - CELL_BASE;
        u = {1'b0, glyph_idx[4:0], 3'b000};
        v = {1'b0, glyph_idx[7:5], 4'b0000};
        slot = (text_color >= PALETTE_ENTRIES) ? 5'(PALETTE_ENTRIES - 1) : text_color;
        rgba = RGBA_TABLE[slot];
        // A palette entry with black RGB draws white and keeps its alpha.
        if (rgba[31:8] == 24'd0)
            rgba[31:8] = 24'hFFFFFF;
        x1 = x0 + {8'd0, advance};
        y1 = y0 + line_height;
        for (int k = 0; k < 4; k++) begin
            corner = 2'(k);
            right  = (corner == VTX_TOP_RIGHT) || (corner == VTX_BOTTOM_RIGHT);
            bottom = (corner == VTX_BOTTOM_RIGHT) || (corner == VTX_BOTTOM_LEFT);
            vtx.x     = right ? x1 : x0;
            vtx.y     = bottom ? y1 : y0;
            vtx.u     = u + (right ? GLYPH_W : 9'd0);
            vtx.v     = v + (bottom ? GLYPH_H : 8'd0);
            vtx.red   = rgba[31:24];
            vtx.green = rgba[23:16];
            vtx.blue  = rgba[15:8];
            vtx.alpha = rgba[7:0];
            vtx.last  = (corner == VTX_BOTTOM_LEFT);
            expected_vertices.push_back(vtx);
        end
    endtask

    task automatic log_vertex_error(input string reason, input t_vertex want,
                                    input t_vertex got);
        o_error_count++;
        if (o_error_count <= MAX_REPORTS)
            $display("%0t: vertex %s: expected x=%0d y=%0d u=%0d v=%0d rgba=%h end=%b,",
                     $time, reason, $signed(want.x), $signed(want.y), want.u, want.v,
                     {want.red, want.green, want.blue, want.alpha}, want.last,
                     " got x=%0d y=%0d u=%0d v=%0d rgba=%h end=%b",
                     $signed(got.x), $signed(got.y), got.u, got.v,
                     {got.red, got.green, got.blue, got.alpha}, got.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            display_on    = 1'b0;
            scale_on      = 1'b0;
            cursor_x      = '0;
            cursor_y      = '0;
            line_start_x  = '0;
            line_height   = '0;
            advance       = '0;
            text_color    = '0;
            o_error_count = 0;
            expected_vertices.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DISPLAY_ENABLE)
                    display_on = i_cfg_data;
                else
                    scale_on = i_cfg_data;
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.func == FUNC_BEGIN) begin
                    load_text_header();
                end else if (i_item.char_code == CODE_NEWLINE) begin
                    cursor_y = cursor_y + line_height;
                    cursor_x = line_start_x;
                end else if (i_item.char_code != CODE_NONE) begin
                    predict_glyph_quad(i_item.char_code);
                end
            end
            if (i_vertex.valid && i_vertex.ready) begin
                observed = '{i_vertex.vertex_x, i_vertex.vertex_y, i_vertex.tex_u,
                             i_vertex.tex_v, i_vertex.red, i_vertex.green, i_vertex.blue,
                             i_vertex.alpha, i_vertex.quad_end};
                if (expected_vertices.size() == 0) begin
                    log_vertex_error("transaction with no quad pending", '0, observed);
                end else begin
                    oldest = expected_vertices.pop_front();
                    if (observed !== oldest)
                        log_vertex_error("mismatch", oldest, observed);
                end
            end
        end
        o_outstanding <= expected_vertices.size();
    end

endmodule

>>> tb/text_glyph_quad_generator_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the text glyph quad generator: drives text items and configuration,
// takes vertices with random back-pressure and gives the verdict of tgq_vertex_checker.
// Depends on tgq_pkg, tgq_in_if, tgq_out_if, text_glyph_quad_generator_top and the checker.
module text_glyph_quad_generator_top_tb;
    import tgq_pkg::*;

    localparam int CYCLE_LIMIT    = 100000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RX_HOLD_CYCLES = 80;

    typedef struct packed {
        logic        func;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [4:0]  color;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [7:0]  code;
    } t_text_item;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic cfg_data;
    int   idle_pct = 19;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   error_count;
    int   outstanding;

    tgq_in_if  item_ch ();
    tgq_out_if vertex_ch ();

    text_glyph_quad_generator_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_ch),
        .o_vertex    (vertex_ch)
    );

    tgq_vertex_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_item        (item_ch),
        .i_vertex      (vertex_ch),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_glyph_quad_generator_top_tb failed");
            $finish;
        end
    end

    // Vertex receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        vertex_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                vertex_ch.ready = 1'b0;
            end else begin
                vertex_ch.ready = ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    function automatic t_text_item begin_item(input logic [15:0] sx, input logic [15:0] sy,
                                              input logic [4:0] color, input logic [7:0] w,
                                              input logic [7:0] h);
        return '{FUNC_BEGIN, sx, sy, color, w, h, 8'($urandom)};
    endfunction

    // Header fields of a character item are ignored by the block, so they carry noise.
    function automatic t_text_item char_item(input logic [7:0] code);
        return '{FUNC_CHAR, 16'($urandom), 16'($urandom), 5'($urandom), 8'($urandom),
                 8'($urandom), code};
    endfunction

    function automatic t_text_item random_begin();
        logic [15:0] sx;
        logic [15:0] sy;
        logic [4:0]  color;
        logic [7:0]  w;
        logic [7:0]  h;
        sx    = ($urandom_range(0, 99) < 60) ? 16'($urandom_range(0, 640)) : 16'($urandom);
        sy    = ($urandom_range(0, 99) < 60) ? 16'($urandom_range(0, 480)) : 16'($urandom);
        color = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, PALETTE_ENTRIES - 1))
                                             : 5'($urandom_range(PALETTE_ENTRIES, 31));
        w     = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(4, 16)) : 8'($urandom);
        h     = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(8, 24)) : 8'($urandom);
        return begin_item(sx, sy, color, w, h);
    endfunction

    function automatic logic [7:0] random_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 8'($urandom_range(8'h21, 8'h7E));
        else if (roll < 68)
            return 8'($urandom_range(CODE_SPECIAL1, CODE_SPECIAL4));
        else if (roll < 76)
            return CODE_SPACE;
        else if (roll < 83)
            return CODE_NEWLINE;
        else if (roll < 86)
            return CODE_NONE;
        return 8'($urandom);
    endfunction

    // Offers one item from the falling edge and returns at the edge where it is taken.
    task automatic send_item(input t_text_item it);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid       = 1'b1;
        item_ch.func        = it.func;
        item_ch.start_x     = it.sx;
        item_ch.start_y     = it.sy;
        item_ch.color_index = it.color;
        item_ch.cell_width  = it.w;
        item_ch.cell_height = it.h;
        item_ch.char_code   = it.code;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // Stops offering items and waits until every predicted vertex has been taken.
    task automatic wait_for_drain();
        @(negedge clk);
        item_ch.valid = 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mostly well-formed lines of text: a begin transaction and a short run of characters.
    task automatic send_random_text(input int count);
        int         sent;
        int         run;
        t_text_item it;
        sent = 0;
        while (sent < count) begin
            send_item(random_begin());
            sent++;
            run = $urandom_range(0, 9);
            repeat (run) begin
                it = char_item(random_code());
                send_item(it);
                if (it.code != CODE_NONE)
                    sent++;
            end
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_DISPLAY_ENABLE;
        cfg_data            = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.func        = FUNC_BEGIN;
        item_ch.start_x     = '0;
        item_ch.start_y     = '0;
        item_ch.color_index = '0;
        item_ch.cell_width  = '0;
        item_ch.cell_height = '0;
        item_ch.char_code   = CODE_NONE;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_register(CFG_DISPLAY_ENABLE, 1'b1);
        write_register(CFG_PROGRESSIVE_SCALE, 1'b0);

        // Glyph mapping, special punctuation codes, space, newline, code zero and the
        // atlas corners, then wrapping positions and palette indexes past the table.
        send_item(begin_item(16'd0, 16'd0, 5'd0, 8'd8, 8'd16));
        send_item(char_item(8'h41));
        send_item(char_item(CODE_SPECIAL1));
        send_item(char_item(CODE_SPECIAL2));
        send_item(char_item(CODE_SPECIAL3));
        send_item(char_item(CODE_SPECIAL4));
        send_item(char_item(CODE_SPACE));
        send_item(char_item(CODE_NEWLINE));
        send_item(char_item(CODE_NONE));
        send_item(char_item(8'hFF));
        send_item(char_item(8'h1F));
        send_item(begin_item(16'h7FFF, 16'h8000, 5'd24, 8'd255, 8'd255));
        send_item(char_item(8'h7E));
        send_item(char_item(CODE_NEWLINE));
        send_item(char_item(8'h42));
        send_item(begin_item(16'hFFFF, 16'd100, 5'd31, 8'd0, 8'd0));
        send_item(char_item(8'h61));
        wait_for_drain();

        // Three-quarter scaling, including negative rows that round toward minus infinity.
        write_register(CFG_PROGRESSIVE_SCALE, 1'b1);
        send_item(begin_item(16'd0, 16'h8000, 5'd25, 8'd8, 8'd255));
        send_item(char_item(8'h78));
        send_item(char_item(CODE_NEWLINE));
        send_item(begin_item(16'd5, 16'hFFFD, 5'd3, 8'd6, 8'd1));
        send_item(char_item(8'h79));
        send_item(begin_item(16'hFF9C, 16'h7FFF, 5'd12, 8'd12, 8'd12));
        send_item(char_item(8'h7A));
        wait_for_drain();

        // With the display off the cursor still moves but nothing is drawn.
        write_register(CFG_DISPLAY_ENABLE, 1'b0);
        send_item(char_item(8'h43));
        send_item(char_item(8'h44));
        wait_for_drain();
        write_register(CFG_DISPLAY_ENABLE, 1'b1);

        send_random_text(18);
        wait_for_drain();

        write_register(CFG_PROGRESSIVE_SCALE, 1'b0);
        idle_pct = 0;
        send_random_text(18);
        wait_for_drain();

        // Receiver holds off while characters keep coming, so the quad queue fills up.
        hold_req++;
        send_item(begin_item(16'd10, 16'd20, 5'd6, 8'd8, 8'd16));
        repeat (30) send_item(char_item(8'($urandom_range(8'h21, 8'h7E))));
        wait_for_drain();
        idle_pct = 19;

        write_register(CFG_DISPLAY_ENABLE, 1'b0);
        send_random_text(6);
        wait_for_drain();
        write_register(CFG_DISPLAY_ENABLE, 1'b1);
        write_register(CFG_PROGRESSIVE_SCALE, 1'b1);
        send_random_text(15);
        wait_for_drain();

        if (error_count == 0)
            $display("text_glyph_quad_generator_top_tb passed");
        else
            $display("text_glyph_quad_generator_top_tb failed");
        $finish;
    end

endmodule
